>>> design/dhbd_pkg.sv
package dhbd_pkg;

    localparam int VALUE_W = 25;   // Q12.12 signed element
    localparam int SCORE_W = 24;   // Q12.12 unsigned score
    localparam int CLASS_W = 8;
    localparam int COORD_W = 14;
    localparam int DIFF_W  = 28;   // 2*c +/- size - 2*pad, Q12.12
    localparam int PROD_W  = 52;   // DIFF_W x 24-bit unsigned scale, 2^-29 units
    localparam int SPAN_W  = 53;
    localparam int FRAC_SHIFT = 29;
    localparam int BOX_COUNT  = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y         = 3'd5;

    localparam logic [12:0] THRESHOLD_DEFAULT = 13'd1024;
    localparam logic [23:0] INV_SCALE_DEFAULT = 24'd65536;
    localparam logic [12:0] LIMIT_DEFAULT     = 13'd640;

    // column end: products not yet formed
    typedef struct packed {
        logic signed [DIFF_W-1:0] lo_x;
        logic signed [DIFF_W-1:0] hi_x;
        logic signed [DIFF_W-1:0] lo_y;
        logic signed [DIFF_W-1:0] hi_y;
        logic [SCORE_W-1:0]       score;
        logic [CLASS_W-1:0]       cls;
    } diff_stage_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] lo_x;
        logic signed [PROD_W-1:0] hi_x;
        logic signed [PROD_W-1:0] lo_y;
        logic signed [PROD_W-1:0] hi_y;
        logic [SCORE_W-1:0]       score;
        logic [CLASS_W-1:0]       cls;
    } prod_stage_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [SPAN_W-1:0]  span_x;
        logic signed [SPAN_W-1:0]  span_y;
        logic [SCORE_W-1:0]        score;
        logic [CLASS_W-1:0]        cls;
    } clip_stage_t;

    function automatic logic signed [COORD_W-1:0] sat14(input logic signed [24:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 25'sd8191) begin
            r = 14'sd8191;
        end else if (v < -25'sd8192) begin
            r = -14'sd8192;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // start corner: value is known non-negative after the clip at zero
    function automatic logic signed [COORD_W-1:0] lo_coord(input logic signed [PROD_W-1:0] a);
        logic signed [COORD_W-1:0] r;
        if (|a[PROD_W-1:FRAC_SHIFT+13]) begin
            r = 14'sd8191;
        end else begin
            r = {1'b0, a[FRAC_SHIFT+12:FRAC_SHIFT]};
        end
        return r;
    endfunction

    // truncate toward zero, then saturate
    function automatic logic signed [COORD_W-1:0] span_coord(input logic signed [SPAN_W-1:0] d);
        logic signed [SPAN_W-FRAC_SHIFT-1:0] q;
        logic                                inc;
        q   = d[SPAN_W-1:FRAC_SHIFT];
        inc = d[SPAN_W-1] && (|d[FRAC_SHIFT-1:0]);
        q   = q + {{(SPAN_W-FRAC_SHIFT-1){1'b0}}, inc};
        return sat14({q[SPAN_W-FRAC_SHIFT-1], q});
    endfunction

endpackage

>>> design/detection_head_box_decode.sv
// After the last score's request, a result goes through the stage 1, 2, 3 and output registers.
// One element request per cycle while s_tready is high; the argmax compare is combinational.
// The decode runs in a 4-stage pipeline (operands, multipliers, clip, truncate) that collapses
// bubbles, so input stalls only when all stages and the output register hold results.
// Reset (aresetn low, synchronous): position, argmax, pipeline valids cleared; registers
// return to threshold 1024, pads 0, inverse scale 1.0, limits 640.
module detection_head_box_decode #(
    parameter int CLASS_COUNT = 80
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: element_value[24:0], zero fill [31:25]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,
    input  logic                                s_tlast,
    // tdata: left[13:0], top[27:14], right[41:28], bottom[55:42],
    //        best_score[79:56], best_class[87:80]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [87:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dhbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dhbd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dhbd_pkg::*;

    localparam int POS_W = $clog2(CLASS_COUNT + BOX_COUNT);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(CLASS_COUNT + BOX_COUNT - 1);
    localparam logic [POS_W-1:0] FIRST_SCORE = POS_W'(BOX_COUNT);

    // configuration
    logic [12:0] thr_reg, limit_x_reg, limit_y_reg;
    logic [11:0] pad_left_reg, pad_top_reg;
    logic [23:0] inv_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= THRESHOLD_DEFAULT;
            pad_left_reg <= '0;
            pad_top_reg  <= '0;
            inv_reg      <= INV_SCALE_DEFAULT;
            limit_x_reg  <= LIMIT_DEFAULT;
            limit_y_reg  <= LIMIT_DEFAULT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SCORE_THRESHOLD: thr_reg      <= cfg_data[12:0];
                REG_PAD_LEFT:        pad_left_reg <= cfg_data[11:0];
                REG_PAD_TOP:         pad_top_reg  <= cfg_data[11:0];
                REG_INVERSE_SCALE:   inv_reg      <= cfg_data[23:0];
                REG_LIMIT_X:         limit_x_reg  <= cfg_data[12:0];
                REG_LIMIT_Y:         limit_y_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic v1_reg, v2_reg, v3_reg, out_v_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !out_v_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // column accumulation
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [SCORE_W-1:0]        best_reg, best_next;
    logic [CLASS_W-1:0]        cls_reg, cls_next;
    logic signed [VALUE_W-1:0] box_reg [BOX_COUNT];

    logic signed [VALUE_W-1:0] elem;
    logic                      in_fire, is_box, col_end, take, emit;
    logic [SCORE_W-1:0]        fin_score;
    logic [CLASS_W-1:0]        fin_class;

    assign elem    = s_tdata[VALUE_W-1:0];
    assign in_fire = s_tvalid && s_tready;
    assign is_box  = pos_reg < FIRST_SCORE;
    assign col_end = !is_box && (s_tlast || pos_reg == LAST_POS);
    assign take    = elem > $signed({1'b0, best_reg});

    always_comb begin
        fin_score = take ? elem[SCORE_W-1:0] : best_reg;
        fin_class = take ? CLASS_W'(pos_reg - FIRST_SCORE) : cls_reg;
        emit      = in_fire && col_end && (fin_score >= {11'b0, thr_reg});
        pos_next  = pos_reg;
        best_next = best_reg;
        cls_next  = cls_reg;
        if (in_fire) begin
            if (is_box) begin
                pos_next = pos_reg + POS_W'(1);
            end else if (col_end) begin
                pos_next  = '0;
                best_next = '0;
                cls_next  = '0;
            end else begin
                pos_next  = pos_reg + POS_W'(1);
                best_next = fin_score;
                cls_next  = fin_class;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            best_reg <= '0;
            cls_reg  <= '0;
        end else begin
            pos_reg  <= pos_next;
            best_reg <= best_next;
            cls_reg  <= cls_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && is_box) begin
            box_reg[pos_reg[1:0]] <= elem;
        end
    end

    // stage 1: corner offsets in Q12.12, doubled
    diff_stage_t s1_reg, s1_next;
    logic signed [DIFF_W-1:0] cx2, cy2, wx, hy, padx2, pady2;

    always_comb begin
        cx2   = {{2{box_reg[0][VALUE_W-1]}}, box_reg[0], 1'b0};
        cy2   = {{2{box_reg[1][VALUE_W-1]}}, box_reg[1], 1'b0};
        wx    = {{3{box_reg[2][VALUE_W-1]}}, box_reg[2]};
        hy    = {{3{box_reg[3][VALUE_W-1]}}, box_reg[3]};
        padx2 = {3'b0, pad_left_reg, 13'b0};
        pady2 = {3'b0, pad_top_reg, 13'b0};
        s1_next.lo_x  = cx2 - wx - padx2;
        s1_next.hi_x  = cx2 + wx - padx2;
        s1_next.lo_y  = cy2 - hy - pady2;
        s1_next.hi_y  = cy2 + hy - pady2;
        s1_next.score = fin_score;
        s1_next.cls   = fin_class;
    end

    // stage 2: scale products, 2^-29 units
    prod_stage_t s2_reg;
    logic signed [VALUE_W-1:0] inv_s;
    assign inv_s = $signed({1'b0, inv_reg});

    // stage 3: clip, left/top corners, spans
    clip_stage_t s3_next, s3_reg;
    logic signed [PROD_W-1:0] ax, bx, ay, by, limx, limy;

    always_comb begin
        limx = {10'b0, limit_x_reg, 29'b0};
        limy = {10'b0, limit_y_reg, 29'b0};
        ax   = s2_reg.lo_x[PROD_W-1] ? '0 : s2_reg.lo_x;
        ay   = s2_reg.lo_y[PROD_W-1] ? '0 : s2_reg.lo_y;
        bx   = (s2_reg.hi_x > limx) ? limx : s2_reg.hi_x;
        by   = (s2_reg.hi_y > limy) ? limy : s2_reg.hi_y;
        s3_next.left   = lo_coord(ax);
        s3_next.top    = lo_coord(ay);
        s3_next.span_x = {bx[PROD_W-1], bx} - {ax[PROD_W-1], ax};
        s3_next.span_y = {by[PROD_W-1], by} - {ay[PROD_W-1], ay};
        s3_next.score  = s2_reg.score;
        s3_next.cls    = s2_reg.cls;
    end

    // stage 4: truncated spans and far corners
    logic signed [COORD_W-1:0] wspan, hspan, right_c, bottom_c;
    logic signed [COORD_W:0]   rsum, bsum;
    logic [87:0]               out_next, out_reg;

    always_comb begin
        wspan    = span_coord(s3_reg.span_x);
        hspan    = span_coord(s3_reg.span_y);
        rsum     = {s3_reg.left[COORD_W-1], s3_reg.left} + {wspan[COORD_W-1], wspan};
        bsum     = {s3_reg.top[COORD_W-1], s3_reg.top} + {hspan[COORD_W-1], hspan};
        right_c  = sat14({{(24-COORD_W){rsum[COORD_W]}}, rsum});
        bottom_c = sat14({{(24-COORD_W){bsum[COORD_W]}}, bsum});
        out_next = {s3_reg.cls, s3_reg.score, bottom_c, right_c, s3_reg.top, s3_reg.left};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg    <= emit;
            if (rdy2) v2_reg    <= v1_reg;
            if (rdy3) v3_reg    <= v2_reg;
            if (rdy4) out_v_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && emit) begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg) begin
            s2_reg.lo_x  <= s1_reg.lo_x * inv_s;
            s2_reg.hi_x  <= s1_reg.hi_x * inv_s;
            s2_reg.lo_y  <= s1_reg.lo_y * inv_s;
            s2_reg.hi_y  <= s1_reg.hi_y * inv_s;
            s2_reg.score <= s1_reg.score;
            s2_reg.cls   <= s1_reg.cls;
        end
        if (rdy3 && v2_reg) begin
            s3_reg <= s3_next;
        end
        if (rdy4 && v3_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("element position past column length");

    a_col_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && col_end) |=> (pos_reg == '0 && best_reg == '0 && cls_reg == '0))
        else $error("argmax not cleared after column end");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && out_v_reg))
        else $error("input stalled with a free pipeline stage");

    a_out_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[79:56] >= {11'b0, thr_reg}))
        else $error("result below score threshold");
`endif

endmodule

>>> tb/dhbd_detection_checker.sv
module dhbd_detection_checker #(
    parameter int CLASS_COUNT = 80
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [31:0]                         s_tdata,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [87:0]                         m_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [dhbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dhbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatch_count,
    output int                                  boxes_pending,
    output int                                  boxes_checked
);
    import dhbd_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic [SCORE_W-1:0]        score;
        logic [CLASS_W-1:0]        cls;
    } detection_t;

    // register copies
    logic [12:0] thr;
    logic [11:0] pad_l;
    logic [11:0] pad_t;
    logic [23:0] inv_scale;
    logic [12:0] lim_x;
    logic [12:0] lim_y;

    // column state
    int           position;
    longint       box_vals [BOX_COUNT];
    longint       best_score;
    logic [7:0]   best_class;

    detection_t   pending_detections [$];
    int           errors;
    int           checked;

    function automatic longint clamp14(input longint v);
        longint r;
        r = v;
        if (v > 8191) r = 8191;
        if (v < -8192) r = -8192;
        return r;
    endfunction

    // corners of one axis in 2^-29 units, clipped, then truncated toward zero
    function automatic void project_axis(input longint ctr, input longint size,
                                         input longint pad, input longint limit,
                                         input longint scale,
                                         output longint lo, output longint hi);
        longint unit;
        longint near_edge;
        longint far_edge;
        longint lim_fx;
        longint span;
        unit      = longint'(1) <<< FRAC_SHIFT;
        near_edge = (2 * ctr - size - pad * 8192) * scale;
        far_edge  = (2 * ctr + size - pad * 8192) * scale;
        lim_fx    = limit * unit;
        if (near_edge < 0) near_edge = 0;
        if (far_edge > lim_fx) far_edge = lim_fx;
        lo   = clamp14(near_edge / unit);
        span = clamp14((far_edge - near_edge) / unit);
        hi   = clamp14(lo + span);
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin : model
        longint     elem;
        longint     x_lo, x_hi, y_lo, y_hi;
        detection_t want;
        if (!aresetn) begin
            thr        = THRESHOLD_DEFAULT;
            pad_l      = '0;
            pad_t      = '0;
            inv_scale  = INV_SCALE_DEFAULT;
            lim_x      = LIMIT_DEFAULT;
            lim_y      = LIMIT_DEFAULT;
            position   = 0;
            best_score = 0;
            best_class = '0;
            for (int i = 0; i < BOX_COUNT; i++) box_vals[i] = 0;
            pending_detections.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SCORE_THRESHOLD: thr       = cfg_data[12:0];
                    REG_PAD_LEFT:        pad_l     = cfg_data[11:0];
                    REG_PAD_TOP:         pad_t     = cfg_data[11:0];
                    REG_INVERSE_SCALE:   inv_scale = cfg_data[23:0];
                    REG_LIMIT_X:         lim_x     = cfg_data[12:0];
                    REG_LIMIT_Y:         lim_y     = cfg_data[12:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                elem = longint'($signed(s_tdata[VALUE_W-1:0]));
                if (position < BOX_COUNT) begin
                    // tlast means nothing on box elements
                    box_vals[position] = elem;
                    position++;
                end else begin
                    if (elem > best_score) begin
                        best_score = elem;
                        best_class = 8'(position - BOX_COUNT);
                    end
                    if (!s_tlast && position < BOX_COUNT + CLASS_COUNT - 1) begin
                        position++;
                    end else begin
                        if (best_score >= longint'(thr)) begin
                            project_axis(box_vals[0], box_vals[2], longint'(pad_l),
                                         longint'(lim_x), longint'(inv_scale), x_lo, x_hi);
                            project_axis(box_vals[1], box_vals[3], longint'(pad_t),
                                         longint'(lim_y), longint'(inv_scale), y_lo, y_hi);
                            want.left   = x_lo[COORD_W-1:0];
                            want.top    = y_lo[COORD_W-1:0];
                            want.right  = x_hi[COORD_W-1:0];
                            want.bottom = y_hi[COORD_W-1:0];
                            want.score  = best_score[SCORE_W-1:0];
                            want.cls    = best_class;
                            pending_detections = {pending_detections, want};
                        end
                        position   = 0;
                        best_score = 0;
                        best_class = '0;
                    end
                end
            end

            if (m_tvalid && m_tready) begin
                if (pending_detections.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = pending_detections.pop_front();
                    checked++;
                    check_field("left", want.left, $signed(m_tdata[13:0]));
                    check_field("top", want.top, $signed(m_tdata[27:14]));
                    check_field("right", want.right, $signed(m_tdata[41:28]));
                    check_field("bottom", want.bottom, $signed(m_tdata[55:42]));
                    check_field("best_score", want.score, m_tdata[79:56]);
                    check_field("best_class", want.cls, m_tdata[87:80]);
                end
            end
        end
        mismatch_count <= errors;
        boxes_pending  <= pending_detections.size();
        boxes_checked  <= checked;
    end

endmodule

>>> tb/tb_detection_head_box_decode.sv
module tb_detection_head_box_decode;
    import dhbd_pkg::*;

    localparam int CLASS_COUNT   = 80;
    localparam int ITEM_TARGET   = 1750;
    localparam int PHASE_ITEMS   = 120;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [87:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int boxes_pending;
    int boxes_checked;

    int idle_pct  = 13;
    int stall_pct = 13;
    int items_sent;
    int phase_count;
    int score_ceiling = 2304;

    logic [24:0]           box_buf   [BOX_COUNT];
    logic [24:0]           score_buf [CLASS_COUNT];
    logic [CFG_IDX_W-1:0]  cfg_idx_buf [8];
    logic [CFG_DATA_W-1:0] cfg_val_buf [8];

    detection_head_box_decode #(
        .CLASS_COUNT(CLASS_COUNT)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dhbd_detection_checker #(
        .CLASS_COUNT(CLASS_COUNT)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .boxes_pending  (boxes_pending),
        .boxes_checked  (boxes_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_element(input logic [24:0] v, input logic last);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, v};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_anchor(input int n_scores, input bit mark_box, input bit mark_end);
        for (int i = 0; i < BOX_COUNT; i++) begin
            push_element(box_buf[i], mark_box && ($urandom_range(1) == 1));
        end
        for (int i = 0; i < n_scores; i++) begin
            push_element(score_buf[i], (i == n_scores - 1) ? mark_end : 1'b0);
        end
    endtask

    // registers only change with the pipeline empty
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (boxes_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic program_regs(input int count);
        for (int i = 0; i < count; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_buf[i];
            cfg_data  <= cfg_val_buf[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // unused upper bits carry junk; the block must drop them
    task automatic set_config(input int thr, input int pl, input int pt, input int scale,
                              input int lx, input int ly);
        cfg_idx_buf[0] = REG_SCORE_THRESHOLD;
        cfg_val_buf[0] = 24'(thr) | (24'($urandom) & 24'hFFE000);
        cfg_idx_buf[1] = REG_PAD_LEFT;
        cfg_val_buf[1] = 24'(pl) | (24'($urandom) & 24'hFFF000);
        cfg_idx_buf[2] = REG_PAD_TOP;
        cfg_val_buf[2] = 24'(pt) | (24'($urandom) & 24'hFFF000);
        cfg_idx_buf[3] = REG_INVERSE_SCALE;
        cfg_val_buf[3] = 24'(scale);
        cfg_idx_buf[4] = REG_LIMIT_X;
        cfg_val_buf[4] = 24'(lx) | (24'($urandom) & 24'hFFE000);
        cfg_idx_buf[5] = REG_LIMIT_Y;
        cfg_val_buf[5] = 24'(ly) | (24'($urandom) & 24'hFFE000);
        program_regs(6);
        score_ceiling = (thr % 8192) * 2 + 256;
    endtask

    task automatic random_anchor();
        int n;
        int kind;
        int r;
        int j;
        int k;
        bit mark_end;
        kind = $urandom_range(99);
        if (kind < 10) begin
            for (int i = 0; i < BOX_COUNT; i++) box_buf[i] = 25'($urandom);
        end else begin
            box_buf[0] = 25'($urandom_range(0, 700 * 4096));
            box_buf[1] = 25'($urandom_range(0, 700 * 4096));
            box_buf[2] = 25'($urandom_range(0, 300 * 4096));
            box_buf[3] = 25'($urandom_range(0, 300 * 4096));
            if ($urandom_range(19) == 0) box_buf[2] = -box_buf[2];
            if ($urandom_range(19) == 0) box_buf[3] = -box_buf[3];
        end
        n = ($urandom_range(19) == 0) ? CLASS_COUNT : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 10) begin
                score_buf[i] = 25'($urandom);
            end else if (r < 25) begin
                score_buf[i] = -25'($urandom_range(1, 4096));
            end else begin
                score_buf[i] = 25'($urandom_range(0, score_ceiling));
            end
        end
        if (n > 1 && $urandom_range(2) == 0) begin
            j = $urandom_range(0, n - 2);
            k = $urandom_range(j + 1, n - 1);
            score_buf[k] = score_buf[j];
        end
        mark_end = (n < CLASS_COUNT) ? 1'b1 : 1'($urandom_range(1));
        send_anchor(n, $urandom_range(9) == 0, mark_end);
    endtask

    initial begin
        int phase_start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // equal scores: the first one wins
        box_buf[0] = 25'(320 * 4096);
        box_buf[1] = 25'(240 * 4096);
        box_buf[2] = 25'(100 * 4096);
        box_buf[3] = 25'(50 * 4096);
        score_buf[0] = 25'd2048;
        score_buf[1] = 25'd2048;
        score_buf[2] = 25'd1000;
        send_anchor(3, 1'b0, 1'b1);
        // tlast on box elements, all scores negative: no detection
        box_buf[0] = 25'(10 * 4096);
        box_buf[1] = 25'(10 * 4096);
        box_buf[2] = 25'(4 * 4096);
        box_buf[3] = 25'(4 * 4096);
        for (int i = 0; i < BOX_COUNT; i++) push_element(box_buf[i], 1'b1);
        push_element(25'h1000000, 1'b1);
        // field extremes: saturated corners, inverted height
        box_buf[0] = 25'h0FFFFFF;
        box_buf[1] = 25'h1000000;
        box_buf[2] = 25'h0FFFFFF;
        box_buf[3] = 25'h1000000;
        score_buf[0] = 25'h0FFFFFF;
        send_anchor(1, 1'b0, 1'b1);
        // clip at zero and at the limit, score equal to the threshold
        box_buf[0] = 25'(1 * 4096);
        box_buf[1] = 25'(700 * 4096);
        box_buf[2] = 25'(8 * 4096);
        box_buf[3] = 25'(100 * 4096);
        score_buf[0] = 25'd0;
        score_buf[1] = 25'd1024;
        send_anchor(2, 1'b0, 1'b1);
        settle_pipeline();

        // unmapped indexes, threshold above 1.0, zero scale
        cfg_idx_buf[0] = REG_SPARE_A;         cfg_val_buf[0] = 24'($urandom);
        cfg_idx_buf[1] = REG_SPARE_B;         cfg_val_buf[1] = 24'($urandom);
        cfg_idx_buf[2] = REG_SCORE_THRESHOLD; cfg_val_buf[2] = 24'd8191;
        cfg_idx_buf[3] = REG_INVERSE_SCALE;   cfg_val_buf[3] = 24'd0;
        cfg_idx_buf[4] = REG_LIMIT_X;         cfg_val_buf[4] = 24'd8191;
        cfg_idx_buf[5] = REG_LIMIT_Y;         cfg_val_buf[5] = 24'd0;
        program_regs(6);
        box_buf[0] = 25'(320 * 4096);
        box_buf[1] = 25'(320 * 4096);
        box_buf[2] = 25'(64 * 4096);
        box_buf[3] = 25'(64 * 4096);
        score_buf[0] = 25'd8190;
        score_buf[1] = 25'd8191;
        send_anchor(2, 1'b0, 1'b1);
        settle_pipeline();

        phase_count = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase_count)
                0: set_config(0, 0, 0, 65536, 8191, 8191);
                1: set_config(4096, 4095, 4095, 16777215, 0, 0);
                2: set_config(1024, 80, 0, 1, 640, 480);
                3: set_config(8191, 0, 4095, 32768, 8191, 0);
                default: begin
                    set_config($urandom_range(0, 4096),
                               ($urandom_range(9) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 160),
                               ($urandom_range(9) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 160),
                               ($urandom_range(7) == 0) ? $urandom_range(1, 16777215)
                                                        : $urandom_range(16384, 262144),
                               $urandom_range(0, 8191), $urandom_range(0, 8191));
                end
            endcase
            // one long stretch with both sides always ready
            idle_pct  = (phase_count == 2) ? 0 : 13;
            stall_pct = (phase_count == 2) ? 0 : 13;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) random_anchor();
            settle_pipeline();
            phase_count++;
        end

        $display("run covered %0d elements over %0d register settings", items_sent,
                 phase_count + 2);
        $display("%0d detections compared, %0d field mismatches", boxes_checked,
                 mismatch_count);
        if (mismatch_count == 0 && boxes_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout with %0d detections outstanding", boxes_pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
